// ===== hdl/ssm_pkg.sv =====
// Shared types, constants and elaboration-time table functions for the scan core.
`timescale 1ns / 1ps
package ssm_pkg;

   // Field widths fixed by the item format.
   localparam int COEF_W  = 16;
   localparam int STATE_W = 32;
   localparam int DECAY_W = 25;
   localparam int PROD_W  = 48;
   localparam int XDT_W   = 32;
   localparam int CSR_W   = 64;
   localparam int RANGE_SHIFT = 28;   // exp range of 16 in Q8.24 is 2^28

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_RATE_0_3   = 3'd0,
      CSR_RATE_4_7   = 3'd1,
      CSR_RATE_8_11  = 3'd2,
      CSR_RATE_12_15 = 3'd3,
      CSR_SKIP_GAIN  = 3'd4
   } csr_index_type;

   // Sequencer states for one item.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_UPD,
      ST_PROD,
      ST_SUM,
      ST_FIN
   } scan_state_type;

   // Stage enables sent to every lane.
   typedef struct packed {
      logic ld;
      logic look;
      logic upd;
      logic prod;
      logic clear;
   } lane_ctrl_type;

   // Unsigned Q56 product, truncated.
   function automatic logic [63:0] mul_q56(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[119:56];
   endfunction

   // Taylor series of exp(-h) in Q56, through the h^20 term.
   function automatic logic [63:0] exp_series(input logic [63:0] h);
      logic [63:0] sum;
      logic [63:0] term;
      sum  = 64'd1 << 56;
      term = 64'd1 << 56;
      for (int k = 1; k <= 20; k++) begin
         term = mul_q56(term, h) / 64'(k);
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // Table entry idx: ratio raised to idx in Q56, rounded to Q1.24.
   function automatic logic [DECAY_W-1:0] decay_entry(input logic [63:0] ratio,
                                                      input int idx);
      logic [63:0] acc;
      logic [63:0] rnd;
      acc = 64'd1 << 56;
      for (int i = 0; i < idx; i++) begin
         acc = mul_q56(acc, ratio);
      end
      rnd = (acc + (64'd1 << 31)) >> 32;
      return rnd[DECAY_W-1:0];
   endfunction

endpackage

// ===== hdl/ssm_req_if.sv =====
// Input channel of the scan core: one time step per item.
`timescale 1ns / 1ps
interface ssm_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_x;
   logic signed [15:0] step_dt;
   logic [63:0]        input_proj_0_3;
   logic [63:0]        input_proj_4_7;
   logic [63:0]        input_proj_8_11;
   logic [63:0]        input_proj_12_15;
   logic [63:0]        output_proj_0_3;
   logic [63:0]        output_proj_4_7;
   logic [63:0]        output_proj_8_11;
   logic [63:0]        output_proj_12_15;
   logic               clear_state;

   modport source (output valid, sample_x, step_dt, input_proj_0_3, input_proj_4_7,
                   input_proj_8_11, input_proj_12_15, output_proj_0_3, output_proj_4_7,
                   output_proj_8_11, output_proj_12_15, clear_state, input ready);
   modport sink (input valid, sample_x, step_dt, input_proj_0_3, input_proj_4_7,
                 input_proj_8_11, input_proj_12_15, output_proj_0_3, output_proj_4_7,
                 output_proj_8_11, output_proj_12_15, clear_state, output ready);
endinterface

// ===== hdl/ssm_rsp_if.sv =====
// Result channel of the scan core: one output sample per item.
`timescale 1ns / 1ps
interface ssm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] scan_out;

   modport source (output valid, scan_out, input ready);
   modport sink (input valid, scan_out, output ready);
endinterface

// ===== hdl/selective_state_space_scan_core.sv =====
// Top level of the selective state-space scan core.
//
//   channel   direction  handshake          payload
//   req_if    in         valid/ready        sample_x, step_dt, B and C lanes, clear_state
//   rsp_if    out        valid/ready        scan_out
//   csr_*     in         write enable only  index, 64-bit data
//
// An accepted item's operands are captured at its accepting edge; lookup, state
// update, output product and group sum follow in that order, and the final sum
// is then loaded into the result register. The input reopens only once the
// sequencer is back in idle, so no new item is taken before the last one is
// through; the state recurrence fixes one item in flight.
// A finished result waits in the output register while the next item is taken;
// the final stage holds if that register is still full. Synchronous reset clears
// the lane states, the configuration registers, the result valid flag and the sequencer.
`timescale 1ns / 1ps
module selective_state_space_scan_core #(
   parameter int LANES = 16,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   ssm_req_if.sink                    req_if,
   ssm_rsp_if.source                  rsp_if,
   input  logic                       csr_we,
   input  logic [2:0]                 csr_index,
   input  logic [ssm_pkg::CSR_W-1:0]  csr_wdata
);
   // Configuration registers.
   logic [63:0]        rate_ff [4];
   logic signed [15:0] skip_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            rate_ff[i] <= '0;
         end
         skip_gain_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ssm_pkg::CSR_RATE_0_3:   rate_ff[0]   <= csr_wdata;
            ssm_pkg::CSR_RATE_4_7:   rate_ff[1]   <= csr_wdata;
            ssm_pkg::CSR_RATE_8_11:  rate_ff[2]   <= csr_wdata;
            ssm_pkg::CSR_RATE_12_15: rate_ff[3]   <= csr_wdata;
            ssm_pkg::CSR_SKIP_GAIN:  skip_gain_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Sequencer.
   ssm_pkg::scan_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, out_load;
   ssm_pkg::lane_ctrl_type ctrl;

   always_comb begin
      state_in = state_ff;
      out_load = 1'b0;
      accept   = req_if.valid && (state_ff == ssm_pkg::ST_IDLE);
      unique case (state_ff)
         ssm_pkg::ST_IDLE: if (accept) state_in = ssm_pkg::ST_LOOK;
         ssm_pkg::ST_LOOK: state_in = ssm_pkg::ST_UPD;
         ssm_pkg::ST_UPD:  state_in = ssm_pkg::ST_PROD;
         ssm_pkg::ST_PROD: state_in = ssm_pkg::ST_SUM;
         ssm_pkg::ST_SUM:  state_in = ssm_pkg::ST_FIN;
         ssm_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               out_load = 1'b1;
               state_in = ssm_pkg::ST_IDLE;
            end
         end
         default: state_in = ssm_pkg::ST_IDLE;
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_if.ready = (state_ff == ssm_pkg::ST_IDLE);

   // Scalar operands of the item.
   logic signed [15:0]               x_ff;
   logic signed [ssm_pkg::XDT_W-1:0] xdt_ff;
   logic                             clear_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff     <= req_if.sample_x;
         xdt_ff   <= 32'(req_if.sample_x) * 32'(req_if.step_dt);
         clear_ff <= req_if.clear_state;
      end
   end

   always_comb begin
      ctrl.ld    = accept;
      ctrl.look  = (state_ff == ssm_pkg::ST_LOOK);
      ctrl.upd   = (state_ff == ssm_pkg::ST_UPD);
      ctrl.prod  = (state_ff == ssm_pkg::ST_PROD);
      ctrl.clear = clear_ff;
   end

   // Lane operands unpacked from the item and the rate registers.
   logic [255:0] b_all;
   logic [255:0] c_all;
   logic [255:0] a_all;

   assign b_all = {req_if.input_proj_12_15, req_if.input_proj_8_11,
                   req_if.input_proj_4_7, req_if.input_proj_0_3};
   assign c_all = {req_if.output_proj_12_15, req_if.output_proj_8_11,
                   req_if.output_proj_4_7, req_if.output_proj_0_3};
   assign a_all = {rate_ff[3], rate_ff[2], rate_ff[1], rate_ff[0]};

   logic signed [ssm_pkg::PROD_W-1:0] lane_prod [LANES];

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      ssm_lane #(
         .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .rate    ($signed(a_all[l*16 +: 16])),
         .step_dt (req_if.step_dt),
         .in_b    ($signed(b_all[l*16 +: 16])),
         .out_c   ($signed(c_all[l*16 +: 16])),
         .xdt     (xdt_ff),
         .prod    (lane_prod[l])
      );
   end

   // Merge lanes into the output sample.
   logic signed [31:0] merged;

   ssm_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock     (clock),
      .sum_en    (state_ff == ssm_pkg::ST_SUM),
      .prod      (lane_prod),
      .sample_x  (x_ff),
      .skip_gain (skip_gain_ff),
      .result    (merged)
   );

   // Output register.
   logic signed [31:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= merged;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.scan_out = rsp_data_ff;
endmodule

// ===== hdl/ssm_lane.sv =====
// One state lane: decay lookup, input term, state recurrence and output product.
`timescale 1ns / 1ps
module ssm_lane #(
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ssm_pkg::lane_ctrl_type                 ctrl,
   input  logic signed [ssm_pkg::COEF_W-1:0]      rate,
   input  logic signed [ssm_pkg::COEF_W-1:0]      step_dt,
   input  logic signed [ssm_pkg::COEF_W-1:0]      in_b,
   input  logic signed [ssm_pkg::COEF_W-1:0]      out_c,
   input  logic signed [ssm_pkg::XDT_W-1:0]       xdt,
   output logic signed [ssm_pkg::PROD_W-1:0]      prod
);
   localparam int IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
   localparam logic [63:0] STEP_Q56 = 64'((128'(16) << 56) / EXP_TABLE_DEPTH);
   localparam logic [63:0] RATIO_Q56 = ssm_pkg::exp_series(STEP_Q56);

   // Decay table over [-16, 0], built at elaboration.
   logic [ssm_pkg::DECAY_W-1:0] decay_rom [EXP_TABLE_DEPTH + 1];
   for (genvar i = 0; i <= EXP_TABLE_DEPTH; i++) begin : g_rom
      localparam logic [ssm_pkg::DECAY_W-1:0] ENTRY = ssm_pkg::decay_entry(RATIO_Q56, i);
      assign decay_rom[i] = ENTRY;
   end

   logic signed [31:0]                  z_ff;
   logic signed [ssm_pkg::COEF_W-1:0]   b_ff;
   logic signed [ssm_pkg::COEF_W-1:0]   c_ff;
   logic [ssm_pkg::DECAY_W-1:0]         decay_ff;
   logic [ssm_pkg::DECAY_W-1:0]         decay_in;
   logic signed [35:0]                  add_ff;
   logic signed [35:0]                  add_in;
   logic signed [ssm_pkg::STATE_W-1:0]  state_ff;
   logic signed [ssm_pkg::STATE_W-1:0]  state_in;
   logic signed [ssm_pkg::PROD_W-1:0]   prod_ff;

   // Table index from the magnitude of dt*A.
   logic signed [32:0] z_ext;
   logic [32:0]        mag;
   logic [44:0]        scaled;
   logic [16:0]        idx_full;
   logic signed [47:0] in_prod;

   always_comb begin
      z_ext    = 33'(z_ff);
      mag      = 33'(-z_ext);
      scaled   = 45'(mag[30:0]) * 45'(EXP_TABLE_DEPTH) + (45'd1 << (ssm_pkg::RANGE_SHIFT - 1));
      idx_full = scaled[ssm_pkg::RANGE_SHIFT +: 17];
      priority if (!z_ff[31]) begin
         decay_in = decay_rom[0];
      end else if (mag > (33'd1 << ssm_pkg::RANGE_SHIFT)) begin
         decay_in = '0;
      end else if (idx_full > 17'(EXP_TABLE_DEPTH)) begin
         decay_in = decay_rom[EXP_TABLE_DEPTH];
      end else begin
         decay_in = decay_rom[idx_full[IDX_W-1:0]];
      end
      in_prod = 48'(b_ff) * 48'(xdt);
      add_in  = 36'((in_prod + 48'sd2048) >>> 12);
   end

   // Recurrence: state * decay rounded, plus input term, saturated.
   logic signed [ssm_pkg::STATE_W-1:0] base;
   logic signed [57:0]                 keep_prod;
   logic signed [33:0]                 keep;
   logic signed [36:0]                 total;

   always_comb begin
      base      = ctrl.clear ? '0 : state_ff;
      keep_prod = 58'(base) * 58'($signed({1'b0, decay_ff}));
      keep      = 34'((keep_prod + (58'sd1 <<< 23)) >>> 24);
      total     = 37'(keep) + 37'(add_ff);
      priority if (total > 37'sd2147483647) begin
         state_in = 32'sh7FFFFFFF;
      end else if (total < -37'sd2147483648) begin
         state_in = 32'sh80000000;
      end else begin
         state_in = total[31:0];
      end
   end

   // Operand capture and stage registers.
   always_ff @(posedge clock) begin
      if (ctrl.ld) begin
         z_ff <= 32'(step_dt) * 32'(rate);
         b_ff <= in_b;
         c_ff <= out_c;
      end
      if (ctrl.look) begin
         decay_ff <= decay_in;
         add_ff   <= add_in;
      end
      if (ctrl.prod) begin
         prod_ff <= 48'(state_ff) * 48'(c_ff);
      end
   end

   // Lane state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (ctrl.upd) begin
         state_ff <= state_in;
      end
   end

   assign prod = prod_ff;
endmodule

// ===== hdl/ssm_merge.sv =====
// Merging stage: sums lane products, adds the skip term, rounds and saturates.
`timescale 1ns / 1ps
module ssm_merge #(
   parameter int LANES = 16
) (
   input  logic                               clock,
   input  logic                               sum_en,
   input  logic signed [ssm_pkg::PROD_W-1:0]  prod [LANES],
   input  logic signed [15:0]                 sample_x,
   input  logic signed [15:0]                 skip_gain,
   output logic signed [31:0]                 result
);
   localparam int GROUPS = (LANES + 3) / 4;

   logic signed [49:0] group_ff [GROUPS];
   logic signed [49:0] group_in [GROUPS];

   // First level: groups of four lanes.
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_in[g] = '0;
      end
      for (int j = 0; j < LANES; j++) begin
         group_in[j / 4] = group_in[j / 4] + 50'(prod[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (sum_en) begin
         group_ff <= group_in;
      end
   end

   // Second level: group sums plus D*x in Q12.36, then round and saturate.
   logic signed [31:0] skip_prod;
   logic signed [52:0] acc;
   logic signed [40:0] rounded;

   always_comb begin
      skip_prod = 32'(skip_gain) * 32'(sample_x);
      acc = 53'(skip_prod) <<< 12;
      for (int g = 0; g < GROUPS; g++) begin
         acc = acc + 53'(group_ff[g]);
      end
      rounded = 41'((acc + 53'sd2048) >>> 12);
      priority if (rounded > 41'sd2147483647) begin
         result = 32'sh7FFFFFFF;
      end else if (rounded < -41'sd2147483648) begin
         result = 32'sh80000000;
      end else begin
         result = rounded[31:0];
      end
   end
endmodule
